>>> hdl/fqs_pkg.sv
// Shared types and constants for the FIFO queue with search.
`timescale 1ns / 1ps

package fqs_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int DATA_W    = 32;
    localparam int KIND_W    = 2;
    localparam int STAT_W    = 2;
    localparam int POS_W     = 5;

    typedef enum logic [KIND_W-1:0] {
        KIND_ENQ  = 2'd0,
        KIND_DEQ  = 2'd1,
        KIND_SRCH = 2'd2
    } kind_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_EMPTY     = 2'd1,
        STAT_FULL      = 2'd2,
        STAT_NOT_FOUND = 2'd3
    } stat_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DEQ_FILL,
        ST_SRCH_RD,
        ST_SRCH_CMP,
        ST_SRCH_END,
        ST_EMIT
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic  enq;           // write tail, bump tail and count
        logic  deq;           // bump head, drop count, read new head
        logic  fill_front;    // front register from read data
        logic  srch_start;    // latch key, clear walk position and pending match
        logic  srch_rd;       // read entry at head + walk position
        logic  srch_adv;      // step walk position
        logic  pend_set;      // record current position, counted from one, as pending match
        logic  load_res;      // latch status/value of a single-word result
        stat_t res_status;
        logic  res_take_front;
        logic  emit;          // load output register
        logic  emit_pend;     // emit pending match instead of latched result
        logic  emit_last;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic empty;
        logic full;
        logic out_free;
        logic pend_valid;
        logic match;
        logic walk_last;
    } dp_stat_t;

endpackage

>>> hdl/fqs_ctrl.sv
// Controller state machine for the FIFO queue with search.
`timescale 1ns / 1ps

module fqs_ctrl
    import fqs_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic [KIND_W-1:0]   s_kind,
    output logic                s_ready,
    input  dp_stat_t            stat,
    output cmd_t                cmd
);

    state_t state_reg, state_next;
    kind_t  kind;

    assign kind    = kind_t'(s_kind);
    assign s_ready = (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    unique case (kind)
                        KIND_ENQ: begin
                            cmd.load_res = 1'b1;
                            if (stat.full) begin
                                cmd.res_status = STAT_FULL;
                            end else begin
                                cmd.enq        = 1'b1;
                                cmd.res_status = STAT_OK;
                            end
                            state_next = ST_EMIT;
                        end
                        KIND_DEQ: begin
                            cmd.load_res = 1'b1;
                            if (stat.empty) begin
                                cmd.res_status = STAT_EMPTY;
                                state_next     = ST_EMIT;
                            end else begin
                                cmd.deq            = 1'b1;
                                cmd.res_status     = STAT_OK;
                                cmd.res_take_front = 1'b1;
                                state_next         = ST_DEQ_FILL;
                            end
                        end
                        KIND_SRCH: begin
                            cmd.load_res = 1'b1;
                            if (stat.empty) begin
                                cmd.res_status = STAT_EMPTY;
                                state_next     = ST_EMIT;
                            end else begin
                                // not found stands unless a match turns up
                                cmd.res_status = STAT_NOT_FOUND;
                                cmd.srch_start = 1'b1;
                                state_next     = ST_SRCH_RD;
                            end
                        end
                        default: begin
                            // unused kind: word dropped, no result
                        end
                    endcase
                end
            end
            ST_DEQ_FILL: begin
                cmd.fill_front = 1'b1;
                state_next     = ST_EMIT;
            end
            ST_SRCH_RD: begin
                cmd.srch_rd = 1'b1;
                state_next  = ST_SRCH_CMP;
            end
            ST_SRCH_CMP: begin
                // a new match releases the pending one as a non-last word
                if (!(stat.match && stat.pend_valid && !stat.out_free)) begin
                    if (stat.match) begin
                        cmd.pend_set = 1'b1;
                        if (stat.pend_valid) begin
                            cmd.emit      = 1'b1;
                            cmd.emit_pend = 1'b1;
                        end
                    end
                    if (stat.walk_last) begin
                        state_next = ST_SRCH_END;
                    end else begin
                        cmd.srch_adv = 1'b1;
                        state_next   = ST_SRCH_RD;
                    end
                end
            end
            ST_SRCH_END: begin
                if (stat.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.emit_pend = stat.pend_valid;
                    cmd.emit_last = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (stat.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.emit_last = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> hdl/fqs_datapath.sv
// Datapath of the FIFO queue with search: ring store, pointers, output register.
`timescale 1ns / 1ps

module fqs_datapath
    import fqs_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic        [DATA_W-1:0]  item_value,
    input  cmd_t                      cmd,
    output dp_stat_t                  stat,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic        [STAT_W-1:0]  m_status,
    output logic signed [DATA_W-1:0]  m_result_value,
    output logic        [POS_W-1:0]   m_match_position,
    output logic signed [DATA_W-1:0]  m_front_value,
    output logic signed [DATA_W-1:0]  m_rear_value,
    output logic        [POS_W-1:0]   m_occupancy,
    output logic                      m_is_empty,
    output logic                      m_last
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    logic [IDX_W-1:0]  head_reg, tail_reg, pos_reg;
    logic [CNT_W-1:0]  count_reg, pend_pos_reg;
    logic              pend_valid_reg;
    logic [DATA_W-1:0] front_reg, rear_reg, key_reg;
    stat_t             res_status_reg;
    logic [DATA_W-1:0] res_value_reg;

    stat_t             out_status_reg;
    logic [DATA_W-1:0] out_value_reg, out_front_reg, out_rear_reg;
    logic [POS_W-1:0]  out_pos_reg, out_occ_reg;
    logic              out_empty_reg, out_last_reg;
    logic              out_valid_reg, out_valid_next;

    logic [IDX_W-1:0]  head_inc, tail_inc, walk_addr, rd_addr;
    logic [IDX_W:0]    walk_sum;
    logic              is_empty;

    assign head_inc = (head_reg == IDX_W'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign tail_inc = (tail_reg == IDX_W'(DEPTH - 1)) ? '0 : tail_reg + 1'b1;
    assign walk_sum = {1'b0, head_reg} + {1'b0, pos_reg};
    assign walk_addr = (walk_sum >= (IDX_W+1)'(DEPTH))
                     ? IDX_W'(walk_sum - (IDX_W+1)'(DEPTH)) : IDX_W'(walk_sum);
    assign rd_addr  = cmd.deq ? head_inc : walk_addr;
    assign is_empty = (count_reg == '0);

    assign stat.empty      = is_empty;
    assign stat.full       = (count_reg == CNT_W'(DEPTH));
    assign stat.out_free   = !out_valid_reg || m_ready;
    assign stat.pend_valid = pend_valid_reg;
    assign stat.match      = (rdata_reg == key_reg);
    assign stat.walk_last  = (CNT_W'(pos_reg) == count_reg - 1'b1);

    // ring store, one write and one registered read port
    always_ff @(posedge aclk) begin
        if (cmd.enq) begin
            mem[tail_reg] <= item_value;
        end
        if (cmd.deq || cmd.srch_rd) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg       <= '0;
            tail_reg       <= '0;
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
        end else begin
            if (cmd.enq) begin
                tail_reg  <= tail_inc;
                count_reg <= count_reg + 1'b1;
            end
            if (cmd.deq) begin
                head_reg  <= head_inc;
                count_reg <= count_reg - 1'b1;
            end
            if (cmd.srch_start) begin
                pend_valid_reg <= 1'b0;
            end else if (cmd.pend_set) begin
                pend_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.enq) begin
            rear_reg <= item_value;
            if (is_empty) begin
                front_reg <= item_value;
            end
        end
        if (cmd.fill_front) begin
            front_reg <= rdata_reg;
        end
        if (cmd.srch_start) begin
            key_reg <= item_value;
            pos_reg <= '0;
        end else if (cmd.srch_adv) begin
            pos_reg <= pos_reg + 1'b1;
        end
        if (cmd.pend_set) begin
            pend_pos_reg <= CNT_W'(pos_reg) + 1'b1;
        end
        if (cmd.load_res) begin
            res_status_reg <= cmd.res_status;
            res_value_reg  <= cmd.res_take_front ? front_reg : '0;
        end
    end

    // output register
    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.emit) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_status_reg <= cmd.emit_pend ? STAT_OK : res_status_reg;
            out_value_reg  <= cmd.emit_pend ? key_reg : res_value_reg;
            out_pos_reg    <= cmd.emit_pend ? POS_W'(pend_pos_reg) : '0;
            out_front_reg  <= is_empty ? '0 : front_reg;
            out_rear_reg   <= is_empty ? '0 : rear_reg;
            out_occ_reg    <= POS_W'(count_reg);
            out_empty_reg  <= is_empty;
            out_last_reg   <= cmd.emit_last;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_status         = out_status_reg;
    assign m_result_value   = out_value_reg;
    assign m_match_position = out_pos_reg;
    assign m_front_value    = out_front_reg;
    assign m_rear_value     = out_rear_reg;
    assign m_occupancy      = out_occ_reg;
    assign m_is_empty       = out_empty_reg;
    assign m_last           = out_last_reg;

endmodule

>>> hdl/fifo_queue_with_search_core.sv
// Top level of the FIFO queue with search: controller plus datapath.
//
// Input channel s_*: one word per operation, s_kind selects enqueue, dequeue
// or search, s_item_value carries the value to append or to look for. Kind 3
// is accepted and dropped without a result.
// Result channel m_*: enqueue and dequeue give one word; a search gives one
// word per matching entry, front to back, m_last on the final one, or a single
// not-found or empty word. Every word carries front, rear, occupancy and the
// empty flag as they stand after the operation.
// Flow, with the receiver always ready: a dequeue passes through a fill state
// (the new front is fetched over the store's registered read port); a search
// accepts, then reads and compares each held entry in turn, and ends in a state
// for the last word. s_ready is high only while no operation is in progress.
// A result waits in the output register while m_ready is low; the next
// operation is still accepted, and a search halts its walk when a second
// match meets a full output register.
// Reset (aresetn low, synchronous) empties the queue and drops any pending
// result; store contents are not cleared and need no clearing pass.
`timescale 1ns / 1ps

module fifo_queue_with_search_core
    import fqs_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic        [KIND_W-1:0]  s_kind,
    input  logic signed [DATA_W-1:0]  s_item_value,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic        [STAT_W-1:0]  m_status,
    output logic signed [DATA_W-1:0]  m_result_value,
    output logic        [POS_W-1:0]   m_match_position,
    output logic signed [DATA_W-1:0]  m_front_value,
    output logic signed [DATA_W-1:0]  m_rear_value,
    output logic        [POS_W-1:0]   m_occupancy,
    output logic                      m_is_empty,
    output logic                      m_last
);

    cmd_t     cmd;
    dp_stat_t stat;

    fqs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_kind  (s_kind),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    fqs_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .item_value       (s_item_value),
        .cmd              (cmd),
        .stat             (stat),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_result_value   (m_result_value),
        .m_match_position (m_match_position),
        .m_front_value    (m_front_value),
        .m_rear_value     (m_rear_value),
        .m_occupancy      (m_occupancy),
        .m_is_empty       (m_is_empty),
        .m_last           (m_last)
    );

    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> stat.out_free)
        else $error("output register loaded while a word is still held");

    a_enq_not_full: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.enq |-> !stat.full)
        else $error("enqueue issued on a full queue");

    a_deq_not_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.deq |-> !stat.empty)
        else $error("dequeue issued on an empty queue");

    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_is_empty) |-> (m_occupancy == '0 && m_front_value == '0
                                     && m_rear_value == '0))
        else $error("empty word reports stale front, rear or occupancy");

endmodule
